// ===== src/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  // Decoder modes
  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Special characters
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSL   = 8'h5C;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_N     = 8'h6E;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_U     = 8'h75;

  // UTF-8 encoding constants
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // Most results one input byte can cause
  localparam int unsigned MAX_RES = 3;

  // One result transaction
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  // Decoder output bundle: up to three results and their count
  typedef struct packed {
    logic [1:0]          count;
    result_t [MAX_RES-1:0] res;
  } dec_t;

endpackage
`default_nettype wire

// ===== src/jsu_decoder.sv =====
// Escape decoder: mode state and per-byte result generation.
`default_nettype none
module jsu_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  output jsu_pkg::dec_t     dec
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hex_cnt_r, hex_cnt_nxt;
  logic [15:0]    acc_r, acc_nxt;

  // Hex digit value, either case
  logic       hex_ok;
  logic [3:0] hex_val;
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  logic [15:0] cp_full;
  assign cp_full = {acc_r[11:0], hex_val};

  // Simple escape letters mapped to their byte
  logic       esc_ok;
  logic [7:0] esc_byte;
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSL, jsu_pkg::CHR_SLASH: esc_byte = in_byte;
      jsu_pkg::CHR_B: esc_byte = 8'h08;
      jsu_pkg::CHR_F: esc_byte = 8'h0C;
      jsu_pkg::CHR_N: esc_byte = 8'h0A;
      jsu_pkg::CHR_R: esc_byte = 8'h0D;
      jsu_pkg::CHR_T: esc_byte = 8'h09;
      default:        esc_ok   = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    if (accept) begin
      unique case (mode_r)
        jsu_pkg::MODE_WAIT: begin
          hex_cnt_nxt = 2'd0;
          acc_nxt     = 16'd0;
          mode_nxt    = (in_byte == jsu_pkg::CHR_QUOTE) ? jsu_pkg::MODE_STRING
                                                        : jsu_pkg::MODE_WAIT;
        end
        jsu_pkg::MODE_STRING: begin
          if (in_byte == jsu_pkg::CHR_NUL || in_byte == jsu_pkg::CHR_QUOTE) begin
            mode_nxt    = jsu_pkg::MODE_WAIT;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end else if (in_byte == jsu_pkg::CHR_BSL) begin
            mode_nxt = jsu_pkg::MODE_ESCAPE;
          end
        end
        jsu_pkg::MODE_ESCAPE: begin
          if (in_byte == jsu_pkg::CHR_U) begin
            mode_nxt    = jsu_pkg::MODE_HEX;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end else if (esc_ok) begin
            mode_nxt = jsu_pkg::MODE_STRING;
          end else begin
            mode_nxt    = jsu_pkg::MODE_WAIT;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (!hex_ok) begin
            mode_nxt    = jsu_pkg::MODE_WAIT;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = 16'd0;
          end else begin
            acc_nxt     = cp_full;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            if (hex_cnt_r == 2'd3) begin
              mode_nxt = jsu_pkg::MODE_STRING;
            end
          end
        end
        default: mode_nxt = jsu_pkg::MODE_WAIT;
      endcase
    end
  end

  // Results for the current byte
  always_comb begin
    dec.count = 2'd0;
    for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
      dec.res[i] = '{data: 8'd0, kind: jsu_pkg::KIND_BYTE, last: 1'b0};
    end
    unique case (mode_r)
      jsu_pkg::MODE_WAIT: begin
        if (in_byte != jsu_pkg::CHR_QUOTE) begin
          dec.count  = 2'd1;
          dec.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_ERROR, last: 1'b1};
        end
      end
      jsu_pkg::MODE_STRING: begin
        if (in_byte == jsu_pkg::CHR_NUL) begin
          dec.count  = 2'd1;
          dec.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_ERROR, last: 1'b1};
        end else if (in_byte == jsu_pkg::CHR_QUOTE) begin
          dec.count  = 2'd1;
          dec.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_CLOSED, last: 1'b1};
        end else if (in_byte != jsu_pkg::CHR_BSL) begin
          dec.count  = 2'd1;
          dec.res[0] = '{data: in_byte, kind: jsu_pkg::KIND_BYTE, last: 1'b1};
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        if (in_byte != jsu_pkg::CHR_U) begin
          dec.count = 2'd1;
          if (esc_ok) begin
            dec.res[0] = '{data: esc_byte, kind: jsu_pkg::KIND_BYTE, last: 1'b1};
          end else begin
            dec.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_ERROR, last: 1'b1};
          end
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          dec.count  = 2'd1;
          dec.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_ERROR, last: 1'b1};
        end else if (hex_cnt_r == 2'd3) begin
          // UTF-8 encode the finished code point
          if (cp_full <= jsu_pkg::UTF8_MAX1) begin
            dec.count  = 2'd1;
            dec.res[0] = '{data: cp_full[7:0], kind: jsu_pkg::KIND_BYTE, last: 1'b1};
          end else if (cp_full <= jsu_pkg::UTF8_MAX2) begin
            dec.count  = 2'd2;
            dec.res[0] = '{data: jsu_pkg::UTF8_LEAD2 | {3'd0, cp_full[10:6]},
                           kind: jsu_pkg::KIND_BYTE, last: 1'b0};
            dec.res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]},
                           kind: jsu_pkg::KIND_BYTE, last: 1'b1};
          end else begin
            dec.count  = 2'd3;
            dec.res[0] = '{data: jsu_pkg::UTF8_LEAD3 | {4'd0, cp_full[15:12]},
                           kind: jsu_pkg::KIND_BYTE, last: 1'b0};
            dec.res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_full[11:6]},
                           kind: jsu_pkg::KIND_BYTE, last: 1'b0};
            dec.res[2] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]},
                           kind: jsu_pkg::KIND_BYTE, last: 1'b1};
          end
        end
      end
      default: dec.count = 2'd0;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::MODE_WAIT;
      hex_cnt_r <= 2'd0;
      acc_r     <= 16'd0;
    end else begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/json_string_unescaper_top.sv =====
// Top level of the JSON string unescaper: decoder plus result queue.
//
// Usage: source text enters one byte per transaction on in_byte
// (in_valid/in_stall). Decoded bytes, string-closed and error markers
// leave on out_byte/out_result_kind/out_last_of_run (out_valid/out_stall).
// Each input byte causes zero to three result transactions; the last one
// caused by a byte carries out_last_of_run.
// Results are registered in the queue and presented from its head.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver does not stall. A \u escape ending in a
// multibyte code point puts up to three results into the four-entry result
// queue; input is held off while more than one result is waiting.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder
// to waiting for an opening quote.
// When the receiver stalls, queued results hold and in_stall rises as soon
// as two or more results are waiting; nothing is lost or dropped.
`default_nettype none
module json_string_unescaper_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_result_kind,
  output logic            out_last_of_run
);

  localparam int unsigned QDEPTH = 4;

  jsu_pkg::result_t q_r   [QDEPTH];
  jsu_pkg::result_t q_nxt [QDEPTH];
  logic [2:0]       cnt_r, cnt_nxt;
  jsu_pkg::dec_t    dec;
  logic             accept, pop;
  logic [2:0]       base;

  // Handshakes
  assign in_stall = (cnt_r > 3'd1);
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  jsu_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .dec     (dec)
  );

  // Queue update: shift out the taken head, append new results behind
  always_comb begin
    logic [2:0] idx;
    base = cnt_r - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int j = 0; j < jsu_pkg::MAX_RES; j++) begin
      idx = base + 3'(j);
      if (accept && (2'(j) < dec.count)) begin
        q_nxt[idx[1:0]] = dec.res[j];
      end
    end
    cnt_nxt = base + (accept ? {1'b0, dec.count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Result port
  assign out_valid       = (cnt_r != 3'd0);
  assign out_byte        = q_r[0].data;
  assign out_result_kind = q_r[0].kind;
  assign out_last_of_run = q_r[0].last;

endmodule
`default_nettype wire
